// File: design/jci_pkg.sv
// Shared types, constants and register codes of the joystick cursor integrator.
package jci_pkg;

  localparam int unsigned PosBitsDef    = 24;
  localparam int unsigned CurveDepthDef = 256;

  localparam logic [15:0] DeadZoneRst = 16'd6554;
  localparam logic [15:0] ExponentRst = 16'd4096;
  localparam logic [23:0] SpeedRst    = 24'd65536;
  localparam logic [23:0] ScreenRst   = 24'd65536;

  localparam int unsigned AddrW = 5;

  typedef enum logic [2:0] {
    REG_DEAD_ZONE     = 3'd0,
    REG_EXPONENT      = 3'd1,
    REG_SPEED_X       = 3'd2,
    REG_SPEED_Y       = 3'd3,
    REG_SCREEN_WIDTH  = 3'd4,
    REG_SCREEN_HEIGHT = 3'd5
  } reg_idx_e;

  typedef struct packed {
    logic [15:0] dead_zone;
    logic [15:0] exponent;
    logic [23:0] speed_x;
    logic [23:0] speed_y;
    logic [23:0] screen_width;
    logic [23:0] screen_height;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic sq;
    logic root_step;
    logic ratio;
    logic div_step;
    logic log_t;
    logic lk_b;
    logic lk_c;
    logic exp_sel;
    logic calc_l;
    logic calc_e;
    logic grad;
    logic norm;
    logic vm1;
    logic vm2;
    logic vdiv_step;
    logic step;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic moved;
    logic cap;
    logic g_zero;
  } sts_t;

endpackage

// File: design/jci_if.sv
// Stream interfaces for stick requests and cursor results.
interface jci_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] stick_x;
  logic signed [15:0] stick_y;
  logic        [15:0] frame_time;

  modport source (output valid, output stick_x, output stick_y, output frame_time,
                  input ready);
  modport sink (input valid, input stick_x, input stick_y, input frame_time,
                output ready);
endinterface

interface jci_out_if;
  logic               valid;
  logic               ready;
  logic        [23:0] cursor_x;
  logic        [23:0] cursor_y;
  logic signed [25:0] velocity_x;
  logic signed [25:0] velocity_y;
  logic               moved;

  modport source (output valid, output cursor_x, output cursor_y, output velocity_x,
                  output velocity_y, output moved, input ready);
  modport sink (input valid, input cursor_x, input cursor_y, input velocity_x,
                input velocity_y, input moved, output ready);
endinterface

// File: design/jci_ctrl.sv
// Sequencer that steps the datapath through one frame request.
module jci_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  jci_pkg::sts_t sts_i,
  output jci_pkg::cmd_t cmd_o
);
  import jci_pkg::*;

  typedef enum logic [16:0] {
    S_IDLE  = 17'h00001,
    S_SQ    = 17'h00002,
    S_ROOT  = 17'h00004,
    S_RATIO = 17'h00008,
    S_DIV   = 17'h00010,
    S_LOGT  = 17'h00020,
    S_LKB   = 17'h00040,
    S_LKC   = 17'h00080,
    S_LENL  = 17'h00100,
    S_EXPO  = 17'h00200,
    S_GRAD  = 17'h00400,
    S_NORM  = 17'h00800,
    S_VM1   = 17'h01000,
    S_VM2   = 17'h02000,
    S_VDIV  = 17'h04000,
    S_STEP  = 17'h08000,
    S_DONE  = 17'h10000
  } state_e;

  localparam logic [4:0] RootLast = 5'd16;
  localparam logic [4:0] DivLast  = 5'd15;
  localparam logic [4:0] VdivLast = 5'd24;

  state_e     state_q, state_d;
  logic [4:0] cnt_q, cnt_d;
  logic       exp_q, exp_d;
  logic       out_valid_q, out_valid_d;
  cmd_t       cmd;

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    exp_d      = exp_q;
    cmd        = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd.load = 1'b1;
          state_d  = S_SQ;
        end
      end
      S_SQ: begin
        cmd.sq  = 1'b1;
        cnt_d   = RootLast;
        state_d = S_ROOT;
      end
      S_ROOT: begin
        cmd.root_step = 1'b1;
        if (cnt_q == '0) begin
          state_d = S_RATIO;
        end else begin
          cnt_d = cnt_q - 5'd1;
        end
      end
      S_RATIO: begin
        cmd.ratio = 1'b1;
        cnt_d     = DivLast;
        if (!sts_i.moved) begin
          state_d = S_DONE;
        end else if (sts_i.cap) begin
          state_d = S_VM1;
        end else begin
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt_q == '0) begin
          state_d = S_LOGT;
        end else begin
          cnt_d = cnt_q - 5'd1;
        end
      end
      S_LOGT: begin
        cmd.log_t = 1'b1;
        exp_d     = 1'b0;
        state_d   = S_LKB;
      end
      S_LKB: begin
        cmd.lk_b = 1'b1;
        state_d  = S_LKC;
      end
      S_LKC: begin
        cmd.lk_c = 1'b1;
        state_d  = exp_q ? S_NORM : S_LENL;
      end
      S_LENL: begin
        cmd.calc_l = 1'b1;
        state_d    = S_EXPO;
      end
      S_EXPO: begin
        cmd.calc_e = 1'b1;
        state_d    = S_GRAD;
      end
      S_GRAD: begin
        cmd.grad = 1'b1;
        if (sts_i.g_zero) begin
          state_d = S_VM1;
        end else begin
          exp_d   = 1'b1;
          state_d = S_LKB;
        end
      end
      S_NORM: begin
        cmd.norm = 1'b1;
        state_d  = S_VM1;
      end
      S_VM1: begin
        cmd.vm1 = 1'b1;
        state_d = S_VM2;
      end
      S_VM2: begin
        cmd.vm2 = 1'b1;
        cnt_d   = VdivLast;
        state_d = S_VDIV;
      end
      S_VDIV: begin
        cmd.vdiv_step = 1'b1;
        if (cnt_q == '0) begin
          state_d = S_STEP;
        end else begin
          cnt_d = cnt_q - 5'd1;
        end
      end
      S_STEP: begin
        cmd.step = 1'b1;
        state_d  = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd.commit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
    cmd.exp_sel = exp_q;
  end

  assign out_valid_d = cmd.commit ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      exp_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      exp_q       <= exp_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign cmd_o       = cmd;
  assign out_valid_o = out_valid_q;

endmodule

// File: design/jci_dp.sv
// Datapath: root, ratio divider, curve tables, velocity divider and cursor update.
module jci_dp #(
  parameter int unsigned POS_BITS          = jci_pkg::PosBitsDef,
  parameter int unsigned CURVE_TABLE_DEPTH = jci_pkg::CurveDepthDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  jci_pkg::cmd_t      cmd_i,
  output jci_pkg::sts_t      sts_o,
  input  jci_pkg::cfg_t      cfg_i,
  input  logic signed [15:0] stick_x_i,
  input  logic signed [15:0] stick_y_i,
  input  logic        [15:0] frame_time_i,
  output logic        [23:0] cursor_x_o,
  output logic        [23:0] cursor_y_o,
  output logic signed [25:0] velocity_x_o,
  output logic signed [25:0] velocity_y_o,
  output logic               moved_o
);
  import jci_pkg::*;

  localparam int unsigned D  = CURVE_TABLE_DEPTH;
  localparam int unsigned IW = $clog2(D + 1);
  localparam int unsigned TW = 16 + IW;
  localparam int unsigned PW = ((POS_BITS > 25) ? POS_BITS : 25) + 1;
  localparam logic [PW-1:0] PosMax = PW'((64'd1 << POS_BITS) - 64'd1);
  localparam logic [POS_BITS-1:0] PosRst = POS_BITS'(ScreenRst >> 1);

  typedef logic [D:0][17:0] tab_t;

  function automatic logic [15:0] frac_log2(longint unsigned x_in);
    longint unsigned x;
    logic [15:0]     res;
    x   = x_in;
    res = '0;
    for (int b = 15; b >= 0; b--) begin
      x = (x * x) >> 30;
      if (x >= (64'd2 << 30)) begin
        res[b] = 1'b1;
        x      = x >> 1;
      end
    end
    return res;
  endfunction

  function automatic tab_t build_log();
    tab_t            t;
    longint unsigned x;
    for (int i = 0; i < D; i++) begin
      x    = (64'd1 << 30) + ((64'(i) << 30) / D);
      t[i] = 18'(frac_log2(x));
    end
    t[D] = 18'd65536;
    return t;
  endfunction

  function automatic tab_t build_exp();
    tab_t            t;
    longint unsigned target;
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned mid;
    for (int i = 0; i < D; i++) begin
      target = (64'(i) << 16) / D;
      lo     = 64'd65536;
      hi     = 64'd131071;
      for (int k = 0; k < 18; k++) begin
        if (lo < hi) begin
          mid = (lo + hi + 64'd1) >> 1;
          if (64'(frac_log2(mid << 14)) <= target) begin
            lo = mid;
          end else begin
            hi = mid - 64'd1;
          end
        end
      end
      t[i] = 18'(lo);
    end
    t[D] = 18'd131072;
    return t;
  endfunction

  localparam tab_t LogTab = build_log();
  localparam tab_t ExpTab = build_exp();

  function automatic logic [POS_BITS-1:0] move_axis(logic [POS_BITS-1:0] pos, logic neg,
                                                    logic [24:0] mag, logic [23:0] screen);
    logic [PW-1:0] lim;
    logic [PW-1:0] p;
    logic [PW-1:0] m;
    logic [PW-1:0] r;
    lim = PW'(screen);
    if (lim > PosMax) begin
      lim = PosMax;
    end
    p = PW'(pos);
    m = PW'(mag);
    if (neg) begin
      r = (p < m) ? '0 : p - m;
    end else begin
      r = p + m;
    end
    if (r > lim) begin
      r = lim;
    end
    return POS_BITS'(r);
  endfunction

  logic signed [15:0]   sx_q, sy_q;
  logic        [15:0]   dt_q;
  logic        [33:0]   rad_q;
  logic        [17:0]   rrem_q;
  logic        [16:0]   root_q;
  logic        [16:0]   drem_q;
  logic        [15:0]   dq_q;
  logic                 moved_q;
  logic        [3:0]    p_q;
  logic        [TW-1:0] t_q;
  logic        [17:0]   base_q;
  logic        [33:0]   dprod_q;
  logic        [17:0]   lk_q;
  logic        [20:0]   l_q;
  logic        [24:0]   e_q;
  logic        [8:0]    n_q;
  logic        [16:0]   nl_q;
  logic        [33:0]   m1x_q, m1y_q;
  logic        [16:0]   vrem_x_q, vrem_y_q;
  logic        [24:0]   vdvd_x_q, vdvd_y_q;
  logic        [24:0]   vq_x_q, vq_y_q;
  logic        [24:0]   mag_x_q, mag_y_q;
  logic [POS_BITS-1:0]  pos_x_q, pos_y_q, pos_x_d, pos_y_d;
  logic        [23:0]   cur_x_q, cur_y_q;
  logic signed [25:0]   vel_x_q, vel_y_q, vel_x_d, vel_y_d;
  logic                 mv_q;

  logic signed [31:0] sxx, syy;
  logic        [33:0] sq;
  logic        [19:0] rem_sh, trial;
  logic        [16:0] diff, den;
  logic        [17:0] dsh;
  logic        [3:0]  p;
  logic        [31:0] shl;
  logic        [15:0] f_log, f_exp, g;
  logic        [8:0]  n;
  logic        [IW-1:0] idx, idx_n;
  logic        [17:0] ta, tb;
  logic        [15:0] ax, ay;
  logic        [57:0] p2x, p2y;
  logic        [17:0] vsh_x, vsh_y;

  assign sxx    = sx_q * sx_q;
  assign syy    = sy_q * sy_q;
  assign sq     = (34'(unsigned'(sxx)) + 34'(unsigned'(syy))) << 2;
  assign rem_sh = {rrem_q, rad_q[33:32]};
  assign trial  = {1'b0, root_q, 2'b01};

  assign diff = root_q - {1'b0, cfg_i.dead_zone};
  assign den  = 17'd65536 - {1'b0, cfg_i.dead_zone};
  assign dsh  = {drem_q, 1'b0};

  always_comb begin
    p = '0;
    for (int i = 1; i < 16; i++) begin
      if (dq_q[i]) begin
        p = 4'(i);
      end
    end
  end

  assign shl   = 32'(dq_q) << (5'd16 - {1'b0, p});
  assign f_log = shl[15:0];
  assign n     = e_q[24:16];
  assign g     = e_q[15:0];
  assign f_exp = 16'd0 - g;

  assign idx   = t_q[TW-1:16];
  assign idx_n = IW'(idx + 1'b1);
  assign ta    = cmd_i.exp_sel ? ExpTab[idx] : LogTab[idx];
  assign tb    = cmd_i.exp_sel ? ExpTab[idx_n] : LogTab[idx_n];

  assign ax  = sx_q[15] ? 16'(-sx_q) : 16'(sx_q);
  assign ay  = sy_q[15] ? 16'(-sy_q) : 16'(sy_q);
  assign p2x = 58'(m1x_q) * 58'(cfg_i.speed_x);
  assign p2y = 58'(m1y_q) * 58'(cfg_i.speed_y);

  assign vsh_x = {vrem_x_q, vdvd_x_q[24]};
  assign vsh_y = {vrem_y_q, vdvd_y_q[24]};

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      sx_q <= stick_x_i;
      sy_q <= stick_y_i;
      dt_q <= frame_time_i;
    end
    if (cmd_i.sq) begin
      rad_q  <= sq;
      rrem_q <= '0;
      root_q <= '0;
    end
    if (cmd_i.root_step) begin
      rad_q <= rad_q << 2;
      if (rem_sh >= trial) begin
        rrem_q <= 18'(rem_sh - trial);
        root_q <= {root_q[15:0], 1'b1};
      end else begin
        rrem_q <= rem_sh[17:0];
        root_q <= {root_q[15:0], 1'b0};
      end
    end
    if (cmd_i.ratio) begin
      moved_q <= sts_o.moved;
      drem_q  <= diff;
      dq_q    <= '0;
      nl_q    <= 17'd65536;
    end
    if (cmd_i.div_step) begin
      if (dsh >= {1'b0, den}) begin
        drem_q <= 17'(dsh - {1'b0, den});
        dq_q   <= {dq_q[14:0], 1'b1};
      end else begin
        drem_q <= dsh[16:0];
        dq_q   <= {dq_q[14:0], 1'b0};
      end
    end
    if (cmd_i.log_t) begin
      p_q <= p;
      t_q <= TW'(f_log) * TW'(D);
    end
    if (cmd_i.lk_b) begin
      base_q  <= ta;
      dprod_q <= 34'(tb - ta) * 34'(t_q[15:0]);
    end
    if (cmd_i.lk_c) begin
      lk_q <= base_q + 18'(dprod_q >> 16);
    end
    if (cmd_i.calc_l) begin
      l_q <= (21'(5'd16 - {1'b0, p_q}) << 16) - 21'(lk_q);
    end
    if (cmd_i.calc_e) begin
      e_q <= 25'((37'(l_q) * 37'(cfg_i.exponent)) >> 12);
    end
    if (cmd_i.grad) begin
      n_q <= n;
      t_q <= TW'(f_exp) * TW'(D);
      if (sts_o.g_zero) begin
        nl_q <= (n > 9'd16) ? 17'd0 : 17'(17'd65536 >> n[4:0]);
      end
    end
    if (cmd_i.norm) begin
      nl_q <= (n_q > 9'd16) ? 17'd0 : 17'(lk_q >> (n_q[4:0] + 5'd1));
    end
    if (cmd_i.vm1) begin
      m1x_q <= 34'({ax, 1'b0}) * 34'(nl_q);
      m1y_q <= 34'({ay, 1'b0}) * 34'(nl_q);
    end
    if (cmd_i.vm2) begin
      vrem_x_q <= p2x[57:41];
      vdvd_x_q <= p2x[40:16];
      vq_x_q   <= '0;
      vrem_y_q <= p2y[57:41];
      vdvd_y_q <= p2y[40:16];
      vq_y_q   <= '0;
    end
    if (cmd_i.vdiv_step) begin
      vdvd_x_q <= vdvd_x_q << 1;
      vdvd_y_q <= vdvd_y_q << 1;
      if (vsh_x >= {1'b0, root_q}) begin
        vrem_x_q <= 17'(vsh_x - {1'b0, root_q});
        vq_x_q   <= {vq_x_q[23:0], 1'b1};
      end else begin
        vrem_x_q <= vsh_x[16:0];
        vq_x_q   <= {vq_x_q[23:0], 1'b0};
      end
      if (vsh_y >= {1'b0, root_q}) begin
        vrem_y_q <= 17'(vsh_y - {1'b0, root_q});
        vq_y_q   <= {vq_y_q[23:0], 1'b1};
      end else begin
        vrem_y_q <= vsh_y[16:0];
        vq_y_q   <= {vq_y_q[23:0], 1'b0};
      end
    end
    if (cmd_i.step) begin
      mag_x_q <= 25'((41'(vq_x_q) * 41'(dt_q)) >> 16);
      mag_y_q <= 25'((41'(vq_y_q) * 41'(dt_q)) >> 16);
    end
    if (cmd_i.commit) begin
      cur_x_q <= 24'(pos_x_d);
      cur_y_q <= 24'(pos_y_d);
      vel_x_q <= vel_x_d;
      vel_y_q <= vel_y_d;
      mv_q    <= moved_q;
    end
  end

  always_comb begin
    pos_x_d = pos_x_q;
    pos_y_d = pos_y_q;
    vel_x_d = '0;
    vel_y_d = '0;
    if (moved_q) begin
      pos_x_d = move_axis(pos_x_q, sx_q[15], mag_x_q, cfg_i.screen_width);
      pos_y_d = move_axis(pos_y_q, sy_q[15], mag_y_q, cfg_i.screen_height);
      vel_x_d = sx_q[15] ? -$signed({1'b0, vq_x_q}) : $signed({1'b0, vq_x_q});
      vel_y_d = sy_q[15] ? -$signed({1'b0, vq_y_q}) : $signed({1'b0, vq_y_q});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_x_q <= PosRst;
      pos_y_q <= PosRst;
    end else if (cmd_i.commit) begin
      pos_x_q <= pos_x_d;
      pos_y_q <= pos_y_d;
    end
  end

  assign sts_o.moved  = root_q > {1'b0, cfg_i.dead_zone};
  assign sts_o.cap    = diff >= den;
  assign sts_o.g_zero = (g == '0);

  assign cursor_x_o   = cur_x_q;
  assign cursor_y_o   = cur_y_q;
  assign velocity_x_o = vel_x_q;
  assign velocity_y_o = vel_y_q;
  assign moved_o      = mv_q;

  a_ratio_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_step |-> drem_q < den)
    else $error("ratio remainder not below divisor");

  a_vel_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.vdiv_step |-> (vrem_x_q < root_q) && (vrem_y_q < root_q))
    else $error("velocity remainder not below length");

  a_vel_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit && moved_q |->
      (vq_x_q <= {1'b0, cfg_i.speed_x}) && (vq_y_q <= {1'b0, cfg_i.speed_y}))
    else $error("velocity above configured speed");

endmodule

// File: design/joystick_cursor_integrator.sv
// Top level: APB register bank, sequencer and datapath of the cursor integrator.
//
// frame_i carries one request per display frame: stick_x, stick_y (Q1.15) and
// frame_time (2^-16 s). cursor_o returns one result per request: clamped cursor
// position, scaled velocities and the moved flag. Registers sit on the APB port
// at byte addresses 0,4,...,20; the user must write them only while the block is idle,
// which the block itself does not enforce. A request is accepted only while the
// sequencer is idle. A request inside the dead zone skips the ratio divider, curve
// tables and velocity divider; a saturated curve skips the ratio divider and the curve
// tables; a scaled log with no fraction part skips the second table lookup. The work
// is set by the bit-serial square root (17 steps), the ratio divider (16 steps) and
// the velocity divider (25 steps) of the datapath.
// The result sits in an output register; while the receiver stalls the block
// still takes and works one further request, then holds it until the slot frees.
// Reset loads the register reset values and places the cursor at half of the
// reset screen size; curve tables are constants and need no fill.
module joystick_cursor_integrator #(
  parameter int unsigned POS_BITS          = jci_pkg::PosBitsDef,
  parameter int unsigned CURVE_TABLE_DEPTH = jci_pkg::CurveDepthDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  jci_in_if.sink                    frame_i,
  jci_out_if.source                 cursor_o,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [jci_pkg::AddrW-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);
  import jci_pkg::*;

  cfg_t     cfg_q;
  reg_idx_e reg_idx;
  cmd_t     cmd;
  sts_t     sts;
  logic     wr_en;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = reg_idx_e'(paddr[AddrW-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.dead_zone     <= DeadZoneRst;
      cfg_q.exponent      <= ExponentRst;
      cfg_q.speed_x       <= SpeedRst;
      cfg_q.speed_y       <= SpeedRst;
      cfg_q.screen_width  <= ScreenRst;
      cfg_q.screen_height <= ScreenRst;
    end else if (wr_en) begin
      case (reg_idx)
        REG_DEAD_ZONE:     cfg_q.dead_zone     <= pwdata[15:0];
        REG_EXPONENT:      cfg_q.exponent      <= pwdata[15:0];
        REG_SPEED_X:       cfg_q.speed_x       <= pwdata[23:0];
        REG_SPEED_Y:       cfg_q.speed_y       <= pwdata[23:0];
        REG_SCREEN_WIDTH:  cfg_q.screen_width  <= pwdata[23:0];
        REG_SCREEN_HEIGHT: cfg_q.screen_height <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_DEAD_ZONE:     prdata = 32'(cfg_q.dead_zone);
      REG_EXPONENT:      prdata = 32'(cfg_q.exponent);
      REG_SPEED_X:       prdata = 32'(cfg_q.speed_x);
      REG_SPEED_Y:       prdata = 32'(cfg_q.speed_y);
      REG_SCREEN_WIDTH:  prdata = 32'(cfg_q.screen_width);
      REG_SCREEN_HEIGHT: prdata = 32'(cfg_q.screen_height);
      default:           prdata = '0;
    endcase
  end

  jci_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (frame_i.valid),
    .in_ready_o  (frame_i.ready),
    .out_valid_o (cursor_o.valid),
    .out_ready_i (cursor_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  jci_dp #(
    .POS_BITS          (POS_BITS),
    .CURVE_TABLE_DEPTH (CURVE_TABLE_DEPTH)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .cfg_i        (cfg_q),
    .stick_x_i    (frame_i.stick_x),
    .stick_y_i    (frame_i.stick_y),
    .frame_time_i (frame_i.frame_time),
    .cursor_x_o   (cursor_o.cursor_x),
    .cursor_y_o   (cursor_o.cursor_y),
    .velocity_x_o (cursor_o.velocity_x),
    .velocity_y_o (cursor_o.velocity_y),
    .moved_o      (cursor_o.moved)
  );

endmodule

// File: tb/sv/tb_joystick_cursor_integrator.sv
// Self-checking testbench: random and directed stick requests against a cursor predictor.
module tb_joystick_cursor_integrator;
  import jci_pkg::*;

  localparam int CycleLimit = 1000000;
  localparam int Depth      = 256;

  typedef struct {
    logic signed [15:0] sx;
    logic signed [15:0] sy;
    logic        [15:0] dt;
  } stick_req_t;

  typedef struct {
    logic        [23:0] cx;
    logic        [23:0] cy;
    logic signed [25:0] vx;
    logic signed [25:0] vy;
    logic               mv;
  } cursor_res_t;

  logic clk_i;
  logic rst_ni;
  logic psel, penable, pwrite;
  logic [AddrW-1:0] paddr;
  logic [31:0] pwdata, prdata;
  logic pready;

  jci_in_if  frame_if ();
  jci_out_if cursor_if ();

  joystick_cursor_integrator u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .frame_i (frame_if),
    .cursor_o(cursor_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  stick_req_t  pending_reqs[$];
  cursor_res_t expected_cursor[$];
  int errors = 0;
  int cyc = 0;
  logic send_hold = 1'b0;
  int stall_seq = 0;

  cfg_t cfg_shadow;
  longint unsigned pos_x, pos_y;
  longint unsigned log_lut[0:Depth];
  longint unsigned exp_lut[0:Depth];

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic longint unsigned frac_log2(longint unsigned x);
    longint unsigned res;
    res = 0;
    for (int b = 15; b >= 0; b--) begin
      x = (x * x) >> 30;
      if (x >= (64'd2 << 30)) begin
        res |= 64'd1 << b;
        x >>= 1;
      end
    end
    return res;
  endfunction

  task automatic build_curve_luts();
    longint unsigned x, target, lo, hi, mid;
    for (longint unsigned i = 0; i < Depth; i++) begin
      x = (64'd1 << 30) + ((i << 30) / Depth);
      target = (i << 16) / Depth;
      lo = 65536;
      hi = 131071;
      log_lut[i] = frac_log2(x);
      while (lo < hi) begin
        mid = (lo + hi + 1) >> 1;
        if (frac_log2(mid << 14) <= target) lo = mid;
        else hi = mid - 1;
      end
      exp_lut[i] = lo;
    end
    log_lut[Depth] = 65536;
    exp_lut[Depth] = 131072;
  endtask

  function automatic longint unsigned lut_interp(bit use_exp, longint unsigned f);
    longint unsigned t, idx, fr, d, a, b;
    t = (f & 64'hFFFF) * Depth;
    idx = t >> 16;
    fr = t & 64'hFFFF;
    a = use_exp ? exp_lut[idx] : log_lut[idx];
    b = use_exp ? exp_lut[idx + 1] : log_lut[idx + 1];
    d = (b - a) & 64'hFFFF_FFFF;
    return (a + ((d * fr) >> 16)) & 64'hFFFF_FFFF;
  endfunction

  function automatic longint unsigned isqrt(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic longint unsigned response_len(longint unsigned r16, longint unsigned e);
    longint unsigned p, f, lg, l, ex, n, g, val;
    if (r16 >= 65536) return 65536;
    p = 0;
    while (p < 15 && (r16 >> (p + 1)) != 0) p++;
    f = ((r16 << (16 - p)) - 65536) & 64'hFFFF_FFFF;
    lg = lut_interp(1'b0, f);
    l = ((16 - p) << 16) - lg;
    ex = (l * e) >> 12;
    n = ex >> 16;
    g = ex & 64'hFFFF;
    if (g == 0) return n > 16 ? 0 : (64'd65536 >> n);
    val = lut_interp(1'b1, 65536 - g);
    return (n + 1) > 17 ? 0 : (val >> (n + 1));
  endfunction

  function automatic longint axis_speed(longint s, longint unsigned nl, longint unsigned len,
                                        longint unsigned spd);
    longint unsigned mag;
    mag = (s < 0 ? -s : s) * 2;
    mag = (mag * nl * spd) / (len << 16);
    return s < 0 ? -longint'(mag) : longint'(mag);
  endfunction

  function automatic longint unsigned axis_step(longint unsigned pos, longint v,
                                                longint unsigned dt, longint unsigned scr);
    longint unsigned mag, lim;
    lim = scr;
    mag = ((v < 0 ? -v : v) * dt) >> 16;
    if (lim > 64'hFF_FFFF) lim = 64'hFF_FFFF;
    if (v < 0) pos = pos < mag ? 0 : pos - mag;
    else pos = pos + mag;
    return pos > lim ? lim : pos;
  endfunction

  task automatic predict_cursor(stick_req_t rq);
    longint sx, sy, vx, vy;
    longint unsigned len, den, r16, nl;
    cursor_res_t res;
    sx = rq.sx;
    sy = rq.sy;
    vx = 0;
    vy = 0;
    len = isqrt(longint'(sx * sx + sy * sy) << 2);
    res.mv = len > cfg_shadow.dead_zone;
    if (res.mv) begin
      den = 65536 - cfg_shadow.dead_zone;
      r16 = ((len - cfg_shadow.dead_zone) << 16) / den;
      nl = response_len(r16, cfg_shadow.exponent);
      vx = axis_speed(sx, nl, len, cfg_shadow.speed_x);
      vy = axis_speed(sy, nl, len, cfg_shadow.speed_y);
      pos_x = axis_step(pos_x, vx, rq.dt, cfg_shadow.screen_width);
      pos_y = axis_step(pos_y, vy, rq.dt, cfg_shadow.screen_height);
    end
    res.cx = pos_x[23:0];
    res.cy = pos_y[23:0];
    res.vx = vx[25:0];
    res.vy = vy[25:0];
    expected_cursor.push_back(res);
  endtask

  task automatic check_field(string name, longint unsigned exp_v, longint unsigned act_v);
    if (exp_v != act_v) begin
      errors++;
      $display("%0t mismatch %s expected %0h actual %0h", $realtime, name, exp_v, act_v);
    end
  endtask

  // Driver: bursts with random gaps
  int burst_left = 4;
  int gap_left = 0;
  logic offer;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (frame_if.valid && frame_if.ready) begin
        predict_cursor(pending_reqs.pop_front());
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 20);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
        end
      end
      offer = (frame_if.valid && !frame_if.ready) ||
              (gap_left == 0 && !send_hold && pending_reqs.size() > 0);
      if (!offer && gap_left > 0) gap_left--;
      frame_if.valid <= offer;
      if (offer) begin
        frame_if.stick_x    <= pending_reqs[0].sx;
        frame_if.stick_y    <= pending_reqs[0].sy;
        frame_if.frame_time <= pending_reqs[0].dt;
      end
    end
  end

  // Monitor: compare results, stall on its own pattern
  int stall_seen = 0;
  int hold_left = 0;
  int mode = 0;
  int mode_left = 0;
  logic rdy;
  cursor_res_t exp_r;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cursor_if.valid && cursor_if.ready) begin
        if (expected_cursor.size() == 0) begin
          errors++;
          $display("%0t unexpected result expected none actual %0h", $realtime,
                   cursor_if.cursor_x);
        end else begin
          exp_r = expected_cursor.pop_front();
          check_field("cursor_x", exp_r.cx, cursor_if.cursor_x);
          check_field("cursor_y", exp_r.cy, cursor_if.cursor_y);
          check_field("velocity_x", exp_r.vx & 26'h3FF_FFFF, cursor_if.velocity_x & 26'h3FF_FFFF);
          check_field("velocity_y", exp_r.vy & 26'h3FF_FFFF, cursor_if.velocity_y & 26'h3FF_FFFF);
          check_field("moved", exp_r.mv, cursor_if.moved);
        end
      end
      if (stall_seq != stall_seen) begin
        stall_seen = stall_seq;
        hold_left = 600;
      end
      if (hold_left > 0) begin
        hold_left--;
        rdy = 1'b0;
      end else begin
        if (mode_left <= 0) begin
          mode = $urandom_range(0, 2);
          mode_left = $urandom_range(10, 200);
        end
        mode_left--;
        case (mode)
          0: rdy = 1'b1;
          1: rdy = $urandom_range(0, 1);
          default: rdy = ($urandom_range(0, 7) == 0);
        endcase
      end
      cursor_if.ready <= rdy;
    end
  end

  always @(posedge clk_i) begin
    cyc++;
    if (cyc > CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic cfg_write(reg_idx_e idx, logic [31:0] v);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_DEAD_ZONE:     cfg_shadow.dead_zone     = v[15:0];
      REG_EXPONENT:      cfg_shadow.exponent      = v[15:0];
      REG_SPEED_X:       cfg_shadow.speed_x       = v[23:0];
      REG_SPEED_Y:       cfg_shadow.speed_y       = v[23:0];
      REG_SCREEN_WIDTH:  cfg_shadow.screen_width  = v[23:0];
      default:           cfg_shadow.screen_height = v[23:0];
    endcase
  endtask

  task automatic cfg_all(logic [15:0] dz, logic [15:0] ex, logic [23:0] spx,
                         logic [23:0] spy, logic [23:0] sw, logic [23:0] sh);
    cfg_write(REG_DEAD_ZONE, 32'(dz));
    cfg_write(REG_EXPONENT, 32'(ex));
    cfg_write(REG_SPEED_X, 32'(spx));
    cfg_write(REG_SPEED_Y, 32'(spy));
    cfg_write(REG_SCREEN_WIDTH, 32'(sw));
    cfg_write(REG_SCREEN_HEIGHT, 32'(sh));
  endtask

  task automatic push_req(int sx, int sy, int dt);
    stick_req_t rq;
    rq.sx = sx[15:0];
    rq.sy = sy[15:0];
    rq.dt = dt[15:0];
    pending_reqs.push_back(rq);
  endtask

  task automatic push_random(int count);
    int sx, sy, dt, k, r;
    for (int i = 0; i < count; i++) begin
      k = $urandom_range(0, 9);
      dt = ($urandom_range(0, 9) == 0) ? (($urandom_range(0, 1) == 1) ? 65535 : 0)
                                       : $urandom_range(0, 65535);
      if (k <= 5) begin
        sx = $urandom_range(0, 65535);
        sy = $urandom_range(0, 65535);
      end else if (k == 6) begin
        sx = $urandom_range(0, 8000) - 4000;
        sy = $urandom_range(0, 8000) - 4000;
      end else if (k == 7) begin
        sx = ($urandom_range(0, 1) == 1) ? 32767 : -32768;
        sy = ($urandom_range(0, 1) == 1) ? $urandom_range(0, 65535) : 0;
      end else if (k == 8) begin
        r = int'(cfg_shadow.dead_zone >> 1);
        sx = r + $urandom_range(0, 64) - 32;
        sy = $urandom_range(0, 64) - 32;
      end else begin
        sx = 0;
        sy = 0;
      end
      push_req(sx, sy, dt);
    end
  endtask

  task automatic drain();
    while (pending_reqs.size() != 0 || expected_cursor.size() != 0 || frame_if.valid)
      @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  function automatic logic [23:0] rand24();
    case ($urandom_range(0, 4))
      0: return 24'd0;
      1: return 24'hFF_FFFF;
      2: return 24'($urandom_range(0, 4096));
      default: return 24'($urandom_range(0, 24'hFF_FFFF));
    endcase
  endfunction

  initial begin
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    frame_if.valid = 1'b0;
    frame_if.stick_x = '0;
    frame_if.stick_y = '0;
    frame_if.frame_time = '0;
    cursor_if.ready = 1'b0;
    build_curve_luts();
    cfg_shadow.dead_zone = DeadZoneRst;
    cfg_shadow.exponent = ExponentRst;
    cfg_shadow.speed_x = SpeedRst;
    cfg_shadow.speed_y = SpeedRst;
    cfg_shadow.screen_width = ScreenRst;
    cfg_shadow.screen_height = ScreenRst;
    pos_x = ScreenRst >> 1;
    pos_y = ScreenRst >> 1;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: extremes, inside dead zone, saturated curve
    push_req(0, 0, 65535);
    push_req(100, -100, 65535);
    push_req(32767, 32767, 65535);
    push_req(-32768, -32768, 65535);
    push_req(-32768, 32767, 0);
    push_req(32767, 0, 1000);
    push_req(6000, 0, 40000);
    push_req(0, -12000, 65535);
    drain();

    // exponent zero, fastest speed, shrunken screen
    cfg_all(16'd0, 16'd0, 24'hFF_FFFF, 24'hFF_FFFF, 24'd1000, 24'd50);
    push_req(1, 0, 65535);
    push_req(-32768, -32768, 65535);
    push_req(32767, -1, 65535);
    push_req(-200, 300, 12345);
    drain();

    // largest dead zone and exponent
    cfg_all(16'hFFFF, 16'hFFFF, 24'd70000, 24'd0, 24'hFF_FFFF, 24'hFF_FFFF);
    push_req(32767, 32767, 65535);
    push_req(-32768, 0, 65535);
    push_req(32767, 0, 65535);
    drain();

    // curve below resolution, speed zero on x
    cfg_all(16'd0, 16'hFFFF, 24'd0, 24'd100000, 24'd20000, 24'd30000);
    push_req(5, 5, 65535);
    push_req(-3, 2, 65535);
    push_req(-32768, 32767, 65535);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      cfg_all($urandom_range(0, 3) == 0 ? 16'($urandom_range(0, 1) * 16'hFFFF)
                                        : 16'($urandom_range(0, 40000)),
              $urandom_range(0, 3) == 0 ? 16'($urandom_range(0, 1) * 16'hFFFF)
                                        : 16'($urandom_range(0, 16384)),
              rand24(), rand24(), rand24(), rand24());
      push_random(250);
      if (ph == 2) stall_seq++;
      if (ph == 5) begin
        while (pending_reqs.size() > 120) @(posedge clk_i);
        send_hold = 1'b1;
        while (expected_cursor.size() != 0) @(posedge clk_i);
        repeat ($urandom_range(5, 50)) @(posedge clk_i);
        send_hold = 1'b0;
      end
      drain();
    end

    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
